// File: design/drm_pkg.sv
// drm_pkg: shared types, constants and the leaf match function of the
// divisor resubstitution match block. no dependencies.
`default_nettype none

package drm_pkg;

    localparam int MAX_DIVISORS = 64;
    localparam int MAX_LEAVES   = 5;
    localparam int TRUTH_BITS   = 32;
    localparam int ELEM_N       = 5;

    localparam int COST_W      = 16;
    localparam int DIV_IDX_W   = 6;
    localparam int LEAF_IDX_W  = 3;
    localparam int LEAF_CNT_W  = 3;
    localparam int DIV_CNT_W   = $clog2(MAX_DIVISORS + 1);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // reset areas, milli-units
    localparam logic [COST_W-1:0] INV_COST_RST  = 16'd1000;
    localparam logic [COST_W-1:0] AND_COST_RST  = 16'd2000;
    localparam logic [COST_W-1:0] NAND_COST_RST = 16'd1500;
    localparam logic [COST_W-1:0] OR_COST_RST   = 16'd2000;
    localparam logic [COST_W-1:0] NOR_COST_RST  = 16'd1500;
    localparam logic [COST_W-1:0] XOR_COST_RST  = 16'd3000;

    // elementary truth tables of the five cut leaves
    localparam logic [TRUTH_BITS-1:0] ELEM_TT [ELEM_N] = '{
        32'hAAAA_AAAA, 32'hCCCC_CCCC, 32'hF0F0_F0F0, 32'hFF00_FF00, 32'hFFFF_0000
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INV  = 3'd0,
        CFG_AND  = 3'd1,
        CFG_NAND = 3'd2,
        CFG_OR   = 3'd3,
        CFG_NOR  = 3'd4,
        CFG_XOR  = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        GATE_WIRE = 3'd0,
        GATE_INV  = 3'd1,
        GATE_AND  = 3'd2,
        GATE_NAND = 3'd3,
        GATE_OR   = 3'd4,
        GATE_NOR  = 3'd5,
        GATE_XOR  = 3'd6
    } t_gate;

    typedef struct packed {
        logic                  first;
        logic [TRUTH_BITS-1:0] target_truth;
        logic [LEAF_CNT_W-1:0] leaf_count;
        logic [COST_W-1:0]     cost_limit;
        logic [TRUTH_BITS-1:0] divisor_truth;
        logic                  divisor_present;
        logic                  last;
    } t_in_item;

    typedef struct packed {
        logic                  found;
        logic [DIV_IDX_W-1:0]  divisor_index;
        logic                  leaf_used;
        logic [LEAF_IDX_W-1:0] leaf_index;
        t_gate                 gate_kind;
        logic                  divisor_inverted;
        logic                  leaf_inverted;
        logic [COST_W-1:0]     best_cost;
    } t_out_item;

    // chosen candidate, without its cost
    typedef struct packed {
        logic [DIV_IDX_W-1:0]  div_idx;
        logic                  leaf_used;
        logic [LEAF_IDX_W-1:0] leaf_idx;
        t_gate                 gate;
        logic                  dinv;
        logic                  linv;
    } t_choice;

    typedef struct packed {
        t_gate gate;
        logic  dinv;
        logic  linv;
    } t_leaf_match;

    // first match over complement choices (divisor outer, leaf inner),
    // gates tried and, nand, or, nor, xor; wire means no match
    function automatic t_leaf_match match_leaf(
        input logic [TRUTH_BITS-1:0] t,
        input logic [TRUTH_BITS-1:0] d,
        input logic [TRUTH_BITS-1:0] l
    );
        t_leaf_match           res;
        logic [TRUTH_BITS-1:0] a;
        logic [TRUTH_BITS-1:0] b;
        t_gate                 kind;
        res = '{gate: GATE_WIRE, dinv: 1'b0, linv: 1'b0};
        for (int c = 0; c < 4; c++) begin
            a = c[1] ? ~d : d;
            b = c[0] ? ~l : l;
            if (t == (a & b))        kind = GATE_AND;
            else if (t == ~(a & b))  kind = GATE_NAND;
            else if (t == (a | b))   kind = GATE_OR;
            else if (t == ~(a | b))  kind = GATE_NOR;
            else if (t == (a ^ b))   kind = GATE_XOR;
            else                     kind = GATE_WIRE;
            if (res.gate == GATE_WIRE && kind != GATE_WIRE) begin
                res.gate = kind;
                res.dinv = c[1];
                res.linv = c[0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/drm_in_if.sv
// drm_in_if: valid/ready channel carrying one search or divisor item.
// depends on drm_pkg for the item type.
`default_nettype none

interface drm_in_if;
    logic               valid;
    logic               ready;
    drm_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/drm_out_if.sv
// drm_out_if: valid/ready channel carrying one search result item.
// depends on drm_pkg for the item type.
`default_nettype none

interface drm_out_if;
    logic               valid;
    logic               ready;
    drm_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/divisor_resub_match_core.sv
// divisor_resub_match_core: truth table resubstitution divisor matching.
// depends on drm_pkg, drm_in_if and drm_out_if.
`default_nettype none

// A search opens with an item marked first, which loads the 32-bit target
// truth table, the leaf count (saturated at five) and the cost limit; the
// same item then counts as divisor 0 unless it is also marked last. Each
// later item carries one divisor truth table, tested against the target as
// a wire, an inverter, or a two-input gate with one of the cut leaves under
// the four complement choices. A candidate wins only if its area is
// strictly below the running best, which starts at the cost limit; a wire
// match ends the search. The item marked last is not tested and yields the
// single result item of the search. Gate areas come from six 16-bit
// registers written through the plain configuration port only while idle,
// a rule on the user that the block itself does not enforce. An accepted
// item is held in the input register, where the whole match and running-best
// update is worked out combinationally; a last item's result goes into the
// output register, which lets a new item in while a result waits. Rate: one
// item per cycle, except that a last item stalls until that result is taken.
module divisor_resub_match_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [drm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [drm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    drm_in_if.sink                               i_in,
    drm_out_if.source                            o_out
);
    import drm_pkg::*;

    // gate area registers
    logic [COST_W-1:0] r_inv_cost, r_and_cost, r_nand_cost;
    logic [COST_W-1:0] r_or_cost, r_nor_cost, r_xor_cost;

    // input register
    logic     r_in_valid;
    t_in_item r_in;

    // search state
    logic [TRUTH_BITS-1:0] r_target,   n_target;
    logic [LEAF_CNT_W-1:0] r_leaf_cnt, n_leaf_cnt;
    logic [COST_W-1:0]     r_best_cost, n_best_cost;
    t_choice               r_choice,   n_choice;
    logic                  r_found,    n_found;
    logic                  r_stopped,  n_stopped;
    logic [DIV_CNT_W-1:0]  r_div_cnt,  n_div_cnt;

    // output register
    logic      r_out_valid;
    t_out_item r_out, n_out;

    logic          w_go;
    logic          w_in_ready;
    t_leaf_match   w_lm [ELEM_N];
    logic [COST_W-1:0] w_leaf_cost [ELEM_N];
    logic [LEAF_CNT_W-1:0] w_lc_sat;

    // the registered item is processed unless it is a last item and the
    // result slot is still occupied
    assign w_go       = r_in_valid && (!r_in.last || !r_out_valid || o_out.ready);
    assign w_in_ready = !r_in_valid || w_go;

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign w_lc_sat = (r_in.leaf_count > LEAF_CNT_W'(MAX_LEAVES))
                    ? LEAF_CNT_W'(MAX_LEAVES) : r_in.leaf_count;

    // per leaf match against the target in force for this item
    always_comb begin
        for (int l = 0; l < ELEM_N; l++) begin
            w_lm[l] = match_leaf(r_in.first ? r_in.target_truth : r_target,
                                 r_in.divisor_truth, ELEM_TT[l]);
            case (w_lm[l].gate)
                GATE_AND:  w_leaf_cost[l] = r_and_cost;
                GATE_NAND: w_leaf_cost[l] = r_nand_cost;
                GATE_OR:   w_leaf_cost[l] = r_or_cost;
                GATE_NOR:  w_leaf_cost[l] = r_nor_cost;
                GATE_XOR:  w_leaf_cost[l] = r_xor_cost;
                default:   w_leaf_cost[l] = '0;
            endcase
        end
    end

    // next search state and result
    always_comb begin
        // a first item reloads the search before anything else
        if (r_in.first) begin
            n_target    = r_in.target_truth;
            n_leaf_cnt  = w_lc_sat;
            n_best_cost = r_in.cost_limit;
            n_choice    = '0;
            n_found     = 1'b0;
            n_stopped   = 1'b0;
            n_div_cnt   = '0;
        end else begin
            n_target    = r_target;
            n_leaf_cnt  = r_leaf_cnt;
            n_best_cost = r_best_cost;
            n_choice    = r_choice;
            n_found     = r_found;
            n_stopped   = r_stopped;
            n_div_cnt   = r_div_cnt;
        end
        n_out = '0;

        if (r_in.last) begin
            n_stopped = 1'b1;
            if (n_found) begin
                n_out.found            = 1'b1;
                n_out.divisor_index    = n_choice.div_idx;
                n_out.leaf_used        = n_choice.leaf_used;
                n_out.leaf_index       = n_choice.leaf_idx;
                n_out.gate_kind        = n_choice.gate;
                n_out.divisor_inverted = n_choice.dinv;
                n_out.leaf_inverted    = n_choice.linv;
                n_out.best_cost        = n_best_cost;
            end
        end else if (n_div_cnt < DIV_CNT_W'(MAX_DIVISORS)) begin
            if (r_in.divisor_present && !n_stopped) begin
                if (n_target == r_in.divisor_truth && n_best_cost != '0) begin
                    // wire match, nothing can beat it
                    n_best_cost = '0;
                    n_choice    = '{div_idx: n_div_cnt[DIV_IDX_W-1:0], leaf_used: 1'b0,
                                    leaf_idx: '0, gate: GATE_WIRE,
                                    dinv: 1'b0, linv: 1'b0};
                    n_found     = 1'b1;
                    n_stopped   = 1'b1;
                end else begin
                    if (n_target == ~r_in.divisor_truth && r_inv_cost < n_best_cost) begin
                        n_best_cost = r_inv_cost;
                        n_choice    = '{div_idx: n_div_cnt[DIV_IDX_W-1:0],
                                        leaf_used: 1'b0, leaf_idx: '0,
                                        gate: GATE_INV, dinv: 1'b1, linv: 1'b0};
                        n_found     = 1'b1;
                    end
                    // strictly-less chain keeps the earliest of equal costs
                    for (int l = 0; l < ELEM_N; l++) begin
                        if (LEAF_CNT_W'(l) < n_leaf_cnt && w_lm[l].gate != GATE_WIRE
                            && w_leaf_cost[l] < n_best_cost) begin
                            n_best_cost = w_leaf_cost[l];
                            n_choice    = '{div_idx: n_div_cnt[DIV_IDX_W-1:0],
                                            leaf_used: 1'b1,
                                            leaf_idx: LEAF_IDX_W'(l),
                                            gate: w_lm[l].gate,
                                            dinv: w_lm[l].dinv,
                                            linv: w_lm[l].linv};
                            n_found     = 1'b1;
                        end
                    end
                end
            end
            n_div_cnt = n_div_cnt + 1'b1;
        end
    end

    // gate area registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_cost  <= INV_COST_RST;
            r_and_cost  <= AND_COST_RST;
            r_nand_cost <= NAND_COST_RST;
            r_or_cost   <= OR_COST_RST;
            r_nor_cost  <= NOR_COST_RST;
            r_xor_cost  <= XOR_COST_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV:  r_inv_cost  <= i_cfg_wdata;
                CFG_AND:  r_and_cost  <= i_cfg_wdata;
                CFG_NAND: r_nand_cost <= i_cfg_wdata;
                CFG_OR:   r_or_cost   <= i_cfg_wdata;
                CFG_NOR:  r_nor_cost  <= i_cfg_wdata;
                CFG_XOR:  r_xor_cost  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    // search state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target    <= '0;
            r_leaf_cnt  <= '0;
            r_best_cost <= '0;
            r_choice    <= '0;
            r_found     <= 1'b0;
            r_stopped   <= 1'b0;
            r_div_cnt   <= '0;
        end else if (w_go) begin
            r_target    <= n_target;
            r_leaf_cnt  <= n_leaf_cnt;
            r_best_cost <= n_best_cost;
            r_choice    <= n_choice;
            r_found     <= n_found;
            r_stopped   <= n_stopped;
            r_div_cnt   <= n_div_cnt;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && r_in.last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && r_in.last) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for divisor_resub_match_core, with a local
// predictor of the divisor search, random idling and one long output hold
// depends on drm_pkg, drm_in_if, drm_out_if and divisor_resub_match_core
module tb_top;
    import drm_pkg::*;

    // watchdog limit, in cycles with no item moving on either channel; the
    // longest correct quiet stretch comes from the output hold below, and
    // random stalls at 80 in 100 stay far below it
    localparam int unsigned QUIET_LIMIT = 3000;
    // length of the output hold in the back-pressure phase
    localparam int unsigned HOLD_CYCLES = 400;
    // cycles let pass after the last result before the phase ends
    localparam int unsigned SETTLE_CYCLES = 8;

    // elementary truth tables of the five cut leaves
    localparam logic [31:0] LEAF_TT [5] = '{
        32'hAAAA_AAAA, 32'hCCCC_CCCC, 32'hF0F0_F0F0, 32'hFF00_FF00, 32'hFFFF_0000
    };
    // gate areas after reset, in register order
    localparam logic [15:0] AREA_RESET [6] = '{
        16'd1000, 16'd2000, 16'd1500, 16'd2000, 16'd1500, 16'd3000
    };

    typedef enum int {AREAS_KEEP, AREAS_DEFAULT, AREAS_ZERO, AREAS_MAX, AREAS_RANDOM} t_area_plan;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    t_cfg_idx    i_cfg_idx;
    logic [15:0] i_cfg_wdata;

    drm_in_if  in_if ();
    drm_out_if out_if ();

    divisor_resub_match_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // items waiting to be offered, and results owed by closed searches
    t_in_item  divisor_stream [$];
    t_out_item pending_results [$];

    int unsigned items_queued   = 0;
    int unsigned mismatches     = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          squeeze_on     = 1'b0;
    int unsigned hold_cnt       = 0;
    int unsigned quiet_cycles   = 0;
    bit          in_taken       = 1'b0;

    // predictor copy of the gate areas and of the search state
    logic [15:0] gate_area [6];
    logic [31:0] s_target  = '0;
    logic [2:0]  s_leaves  = '0;
    logic [15:0] s_best    = '0;
    t_out_item   s_pick    = '0;   // found flag and chosen candidate, cost in s_best
    bit          s_stopped = 1'b0;
    int unsigned s_pos     = 0;

    t_out_item seen_res;
    t_out_item due_res;

    task automatic report_error(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_error($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    function automatic logic [15:0] area_of(input t_gate g);
        case (g)
            GATE_INV:  return gate_area[CFG_INV];
            GATE_AND:  return gate_area[CFG_AND];
            GATE_NAND: return gate_area[CFG_NAND];
            GATE_OR:   return gate_area[CFG_OR];
            GATE_NOR:  return gate_area[CFG_NOR];
            GATE_XOR:  return gate_area[CFG_XOR];
            default:   return 16'h0;
        endcase
    endfunction

    function automatic logic [31:0] gate_out(input t_gate g, input logic [31:0] a,
                                             input logic [31:0] b);
        case (g)
            GATE_AND:  return a & b;
            GATE_NAND: return ~(a & b);
            GATE_OR:   return a | b;
            GATE_NOR:  return ~(a | b);
            GATE_XOR:  return a ^ b;
            default:   return a;
        endcase
    endfunction

    // first gate that rebuilds the target from divisor and leaf; divisor
    // complement is the outer choice, leaf complement the inner one
    function automatic t_gate leaf_gate(input logic [31:0] t, input logic [31:0] d,
                                        input logic [31:0] l,
                                        output logic dinv, output logic linv);
        logic [31:0] a;
        logic [31:0] b;
        t_gate       g;
        dinv = 1'b0;
        linv = 1'b0;
        for (int cd = 0; cd < 2; cd++) begin
            for (int cl = 0; cl < 2; cl++) begin
                a = (cd != 0) ? ~d : d;
                b = (cl != 0) ? ~l : l;
                if (t == (a & b))       g = GATE_AND;
                else if (t == ~(a & b)) g = GATE_NAND;
                else if (t == (a | b))  g = GATE_OR;
                else if (t == ~(a | b)) g = GATE_NOR;
                else if (t == (a ^ b))  g = GATE_XOR;
                else                    g = GATE_WIRE;
                if (g != GATE_WIRE) begin
                    dinv = (cd != 0);
                    linv = (cl != 0);
                    return g;
                end
            end
        end
        return GATE_WIRE;
    endfunction

    task automatic take_candidate(input logic [15:0] cost, input logic [5:0] pos,
                                  input logic lu, input logic [2:0] leaf,
                                  input t_gate g, input logic dinv, input logic linv);
        s_best                  = cost;
        s_pick.found            = 1'b1;
        s_pick.divisor_index    = pos;
        s_pick.leaf_used        = lu;
        s_pick.leaf_index       = leaf;
        s_pick.gate_kind        = g;
        s_pick.divisor_inverted = dinv;
        s_pick.leaf_inverted    = linv;
    endtask

    // advance the search state by one accepted item; a close owes a result
    task automatic resub_predict(input t_in_item it);
        t_out_item  res;
        t_gate      g;
        logic       dinv;
        logic       linv;
        logic [5:0] pos;
        if (it.first) begin
            s_target  = it.target_truth;
            s_leaves  = (it.leaf_count > 3'd5) ? 3'd5 : it.leaf_count;
            s_best    = it.cost_limit;
            s_stopped = 1'b0;
            s_pos     = 0;
            s_pick    = '0;
        end
        if (it.last) begin
            s_stopped = 1'b1;
            res = '0;
            if (s_pick.found) begin
                res           = s_pick;
                res.best_cost = s_best;
            end
            pending_results.push_back(res);
        end else if (s_pos < MAX_DIVISORS) begin
            pos   = 6'(s_pos);
            s_pos = s_pos + 1;
            if (it.divisor_present && !s_stopped) begin
                if (it.divisor_truth == s_target && s_best != 16'h0) begin
                    // a plain wire wins outright and ends the search
                    take_candidate(16'h0, pos, 1'b0, 3'd0, GATE_WIRE, 1'b0, 1'b0);
                    s_stopped = 1'b1;
                end else begin
                    if (it.divisor_truth == ~s_target && area_of(GATE_INV) < s_best)
                        take_candidate(area_of(GATE_INV), pos, 1'b0, 3'd0, GATE_INV,
                                       1'b1, 1'b0);
                    for (int l = 0; l < int'(s_leaves); l++) begin
                        g = leaf_gate(s_target, it.divisor_truth, LEAF_TT[l], dinv, linv);
                        if (g != GATE_WIRE && area_of(g) < s_best)
                            take_candidate(area_of(g), pos, 1'b1, 3'(l), g, dinv, linv);
                    end
                end
            end
        end
    endtask

    function automatic t_in_item div_item(input logic first, input logic [31:0] tgt,
                                          input logic [2:0] leaves,
                                          input logic [15:0] limit,
                                          input logic [31:0] d, input logic present,
                                          input logic last);
        t_in_item it;
        it.first           = first;
        it.target_truth    = tgt;
        it.leaf_count      = leaves;
        it.cost_limit      = limit;
        it.divisor_truth   = d;
        it.divisor_present = present;
        it.last            = last;
        return it;
    endfunction

    // random item, divisor drawn mostly from tables related to the target
    function automatic t_in_item rand_item(input logic [31:0] tgt, input logic [31:0] base);
        t_in_item it;
        it = div_item(1'b0, $urandom(), 3'($urandom_range(7)), 16'($urandom_range(65535)),
                      $urandom(), ($urandom_range(9) != 0), 1'b0);
        case ($urandom_range(19))
            0:             it.divisor_truth = tgt;
            1, 2:          it.divisor_truth = ~tgt;
            3, 4, 5, 6, 7: it.divisor_truth = base;
            8, 9:          it.divisor_truth = ~base;
            10:            it.divisor_truth = LEAF_TT[$urandom_range(4)];
            default:       ;
        endcase
        return it;
    endfunction

    task automatic queue_item(input t_in_item it);
        divisor_stream.push_back(it);
        items_queued++;
    endtask

    // one search: opening item, divisors, close; now and then broken or
    // followed by stray items
    task automatic push_search(input int max_div);
        t_in_item    it;
        logic [31:0] tgt;
        logic [31:0] base;
        int          n_div;
        int          shape;
        int          lf;
        base = $urandom();
        lf   = $urandom_range(4);
        case ($urandom_range(9))
            0, 1:    tgt = $urandom();
            2:       tgt = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            3:       tgt = LEAF_TT[lf];
            default: tgt = gate_out(t_gate'(3'($urandom_range(6, 2))),
                                    ($urandom_range(1) != 0) ? ~base : base,
                                    ($urandom_range(1) != 0) ? ~LEAF_TT[lf] : LEAF_TT[lf]);
        endcase
        shape = $urandom_range(99);
        if (shape < 4)       n_div = 0;                        // opened and closed at once
        else if (shape < 7)  n_div = $urandom_range(70, 64);   // reaches or runs past the divisor limit
        else if (shape < 20) n_div = $urandom_range(30, 9);
        else                 n_div = $urandom_range(8, 1);
        if (n_div > max_div)
            n_div = max_div;

        it = rand_item(tgt, base);
        it.first        = 1'b1;
        it.target_truth = tgt;
        it.leaf_count   = ($urandom_range(1) != 0) ? 3'd5 : 3'($urandom_range(7));
        case ($urandom_range(7))
            0:       it.cost_limit = 16'h0;
            1:       it.cost_limit = 16'hFFFF;
            2, 3:    it.cost_limit = 16'($urandom_range(65535));
            default: it.cost_limit = 16'($urandom_range(5000));
        endcase
        it.last = (n_div == 0);
        queue_item(it);
        for (int k = 1; k < n_div; k++)
            queue_item(rand_item(tgt, base));
        // an abandoned search is simply reopened by the next one
        if (n_div != 0 && $urandom_range(19) != 0) begin
            it = rand_item(tgt, base);
            it.last = 1'b1;
            queue_item(it);
        end
        case ($urandom_range(19))
            0: repeat ($urandom_range(3, 1)) queue_item(rand_item(tgt, base));
            1: begin
                it = rand_item(tgt, base);
                it.last = 1'b1;
                queue_item(it);
            end
            default: ;
        endcase
    endtask

    // write all six areas, only ever with the block idle
    task automatic program_areas(input t_area_plan plan);
        logic [15:0] v;
        for (int i = 0; i < 6; i++) begin
            case (plan)
                AREAS_DEFAULT: v = AREA_RESET[i];
                AREAS_ZERO:    v = 16'h0;
                AREAS_MAX:     v = 16'hFFFF;
                default: begin
                    case ($urandom_range(3))
                        0:       v = 16'h0;
                        1:       v = 16'hFFFF;
                        2:       v = 16'($urandom_range(65535));
                        default: v = 16'($urandom_range(4000, 500));
                    endcase
                end
            endcase
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= t_cfg_idx'(i);
            i_cfg_wdata <= v;
            gate_area[i] = v;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input t_area_plan plan, input int unsigned send_pct,
                             input int unsigned stall_pct, input int unsigned n_items,
                             input bit squeeze, input int max_div);
        int unsigned stop_at;
        if (plan != AREAS_KEEP)
            program_areas(plan);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        squeeze_on     = squeeze;
        stop_at        = items_queued + n_items;
        while (items_queued < stop_at)
            push_search(max_div);
        // drain: every item offered and taken, every result back
        while (divisor_stream.size() != 0 || in_if.valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // item driver, new values at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (divisor_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                in_if.data  <= divisor_stream.pop_front();
                in_if.valid <= 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result receiver; the long hold starts once when the squeeze phase opens
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (squeeze_on && hold_cnt < HOLD_CYCLES) begin
            out_if.ready <= 1'b0;
            hold_cnt     <= hold_cnt + 1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on every accepted item, check every accepted result
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready)
            resub_predict(in_if.data);
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_results.size() == 0) begin
                report_error("result item with no closed search waiting");
            end else begin
                due_res  = pending_results.pop_front();
                seen_res = out_if.data;
                check_field("found", seen_res.found, due_res.found);
                check_field("divisor_index", seen_res.divisor_index, due_res.divisor_index);
                check_field("leaf_used", seen_res.leaf_used, due_res.leaf_used);
                check_field("leaf_index", seen_res.leaf_index, due_res.leaf_index);
                check_field("gate_kind", seen_res.gate_kind, due_res.gate_kind);
                check_field("divisor_inverted", seen_res.divisor_inverted,
                            due_res.divisor_inverted);
                check_field("leaf_inverted", seen_res.leaf_inverted, due_res.leaf_inverted);
                check_field("best_cost", seen_res.best_cost, due_res.best_cost);
            end
        end
    end

    // watchdog on cycles where no item moves
    always @(posedge i_clk) begin
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        logic [31:0] d;
        logic [31:0] tgt;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = CFG_INV;
        i_cfg_wdata  = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        out_if.ready = 1'b0;
        for (int i = 0; i < 6; i++)
            gate_area[i] = AREA_RESET[i];
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: a close before any search gives the reset state
        queue_item(div_item(1'b0, 32'h0, 3'd0, 16'h0, 32'h0, 1'b0, 1'b1));
        // one search per two-input gate, target built from a leaf and the divisor;
        // the first of them asks for seven leaves, which saturates
        for (int j = 0; j < 5; j++) begin
            d   = $urandom();
            tgt = gate_out(t_gate'(3'(j + 2)), d, LEAF_TT[j]);
            queue_item(div_item(1'b1, tgt, (j == 0) ? 3'd7 : 3'd5, 16'hFFFF, ~d, 1'b0, 1'b0));
            queue_item(div_item(1'b0, $urandom(), 3'($urandom_range(7)),
                                16'($urandom_range(65535)), d, 1'b1, 1'b0));
            queue_item(div_item(1'b0, 32'h0, 3'd0, 16'h0, 32'h0, 1'b0, 1'b1));
        end
        // inverter on the all-zero target, no leaves
        queue_item(div_item(1'b1, 32'h0, 3'd0, 16'hFFFF, $urandom(), 1'b0, 1'b0));
        queue_item(div_item(1'b0, 32'h0, 3'd0, 16'h0, 32'hFFFF_FFFF, 1'b1, 1'b0));
        queue_item(div_item(1'b0, 32'h0, 3'd0, 16'h0, 32'h0, 1'b0, 1'b1));
        // wire match on the opening item stops the search; later items ignored,
        // a second close repeats the result
        queue_item(div_item(1'b1, 32'hFFFF_FFFF, 3'd5, 16'd1, 32'hFFFF_FFFF, 1'b1, 1'b0));
        queue_item(div_item(1'b0, 32'h0, 3'd5, 16'hFFFF, 32'h0, 1'b1, 1'b0));
        queue_item(div_item(1'b0, 32'h0, 3'd0, 16'h0, 32'h0, 1'b0, 1'b1));
        queue_item(div_item(1'b0, $urandom(), 3'd5, 16'hFFFF, 32'h0, 1'b1, 1'b0));
        queue_item(div_item(1'b0, 32'h0, 3'd0, 16'h0, 32'h0, 1'b0, 1'b1));
        // opened and closed by one item
        queue_item(div_item(1'b1, $urandom(), 3'd5, 16'd3000, $urandom(), 1'b1, 1'b1));
        // zero cost limit: nothing can win, not even a wire
        queue_item(div_item(1'b1, 32'h1234_5678, 3'd1, 16'h0, 32'h1234_5678, 1'b1, 1'b0));
        queue_item(div_item(1'b0, 32'h0, 3'd0, 16'h0, 32'hEDCB_A987, 1'b1, 1'b0));
        queue_item(div_item(1'b0, 32'h0, 3'd0, 16'h0, 32'h0, 1'b0, 1'b1));

        // areas at reset, no idling
        run_phase(AREAS_KEEP, 0, 0, 200, 1'b0, 70);
        // all areas zero, sender mostly idle
        run_phase(AREAS_ZERO, 80, 0, 180, 1'b0, 70);
        // all areas at the top, receiver mostly stalling
        run_phase(AREAS_MAX, 0, 80, 180, 1'b0, 70);
        // random areas, both sides idling now and then
        run_phase(AREAS_RANDOM, 30, 30, 180, 1'b0, 70);
        // short searches against a long output hold, so a close backs up
        run_phase(AREAS_RANDOM, 0, 0, 150, 1'b1, 3);
        // reset areas written back, receiver stalling
        run_phase(AREAS_DEFAULT, 0, 80, 200, 1'b0, 70);

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
